>>> hw/rtl/evhp_pkg.sv
package evhp_pkg;

    localparam int MaxVlanTags = 2;
    localparam int DestEnd     = 6;
    localparam int SrcEnd      = 12;
    localparam int EthHdrLen   = 14;

    localparam logic [15:0] TYPE_8021Q  = 16'h8100;
    localparam logic [15:0] TYPE_8021AD = 16'h88A8;
    localparam logic [11:0] VID_MASK    = 12'hFFF;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [1:0]  tag_count;
        logic [11:0] outer_vid;
        logic [11:0] inner_vid;
        logic [4:0]  header_bytes;
        logic        truncated;
    } t_result;

    function automatic logic is_vlan_type(input logic [15:0] t);
        return (t == TYPE_8021Q) || (t == TYPE_8021AD);
    endfunction

endpackage

>>> hw/rtl/evhp_parse.sv
module evhp_parse #(
    parameter int MAX_VLAN_TAGS = evhp_pkg::MaxVlanTags
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_push,
    output evhp_pkg::t_result o_result
);
    import evhp_pkg::*;

    logic [4:0]  r_byte_index, n_byte_index;
    logic        r_header_done, n_header_done;
    logic [47:0] r_dest_shift, n_dest_shift;
    logic [47:0] r_src_shift, n_src_shift;
    logic [15:0] r_type_shift, n_type_shift;
    logic [15:0] r_tci_shift, n_tci_shift;
    logic [1:0]  r_tags_seen, n_tags_seen;
    logic [11:0] r_vid_store [2];
    logic [11:0] n_vid_store [2];
    logic [7:0]  r_type_hi, n_type_hi;

    logic [1:0]  pos;
    logic        boundary;
    logic        done_now;
    logic        emit;
    logic        trunc;

    always_comb begin
        n_byte_index  = r_byte_index;
        n_header_done = r_header_done;
        n_dest_shift  = r_dest_shift;
        n_src_shift   = r_src_shift;
        n_type_shift  = r_type_shift;
        n_tci_shift   = r_tci_shift;
        n_tags_seen   = r_tags_seen;
        n_vid_store   = r_vid_store;
        n_type_hi     = r_type_hi;
        pos           = 2'(r_byte_index - 5'(EthHdrLen));
        boundary      = 1'b0;
        done_now      = 1'b0;
        emit          = 1'b0;
        trunc         = 1'b0;
        if (!r_header_done) begin
            if (r_byte_index < 5'(DestEnd)) begin
                n_dest_shift = {r_dest_shift[39:0], i_data_byte};
            end else if (r_byte_index < 5'(SrcEnd)) begin
                n_src_shift = {r_src_shift[39:0], i_data_byte};
            end else if (r_byte_index < 5'(EthHdrLen)) begin
                n_type_shift = {r_type_shift[7:0], i_data_byte};
            end else begin
                case (pos)
                    2'd0, 2'd1: n_tci_shift = {r_tci_shift[7:0], i_data_byte};
                    2'd2:       n_type_hi = i_data_byte;
                    default: begin
                        n_type_shift = {r_type_hi, i_data_byte};
                        n_vid_store[r_tags_seen[0]] = r_tci_shift[11:0] & VID_MASK;
                        n_tags_seen = r_tags_seen + 2'd1;
                    end
                endcase
            end
            n_byte_index = r_byte_index + 5'd1;
            boundary = (n_byte_index >= 5'(EthHdrLen)) &&
                       (2'(n_byte_index - 5'(EthHdrLen)) == 2'd0);
            done_now = boundary && (!is_vlan_type(n_type_shift) ||
                                    (n_tags_seen >= 2'(MAX_VLAN_TAGS)));
            n_header_done = done_now;
            emit  = done_now || i_last_byte;
            trunc = !done_now && (n_byte_index < 5'(EthHdrLen));
        end
    end

    always_comb begin
        o_result = '0;
        if (trunc) begin
            o_result.truncated = 1'b1;
        end else begin
            o_result.dest_mac     = n_dest_shift;
            o_result.src_mac      = n_src_shift;
            o_result.ether_type   = n_type_shift;
            o_result.tag_count    = n_tags_seen;
            o_result.outer_vid    = (n_tags_seen >= 2'd1) ? n_vid_store[0] : 12'd0;
            o_result.inner_vid    = (n_tags_seen >= 2'd2) ? n_vid_store[1] : 12'd0;
            o_result.header_bytes = 5'(EthHdrLen) + {1'b0, n_tags_seen, 2'b00};
        end
    end

    assign o_push = i_acc && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_acc && i_last_byte)) begin
            r_byte_index   <= '0;
            r_header_done  <= 1'b0;
            r_dest_shift   <= '0;
            r_src_shift    <= '0;
            r_type_shift   <= '0;
            r_tci_shift    <= '0;
            r_tags_seen    <= '0;
            r_vid_store[0] <= '0;
            r_vid_store[1] <= '0;
            r_type_hi      <= '0;
        end else if (i_acc) begin
            r_byte_index  <= n_byte_index;
            r_header_done <= n_header_done;
            r_dest_shift  <= n_dest_shift;
            r_src_shift   <= n_src_shift;
            r_type_shift  <= n_type_shift;
            r_tci_shift   <= n_tci_shift;
            r_tags_seen   <= n_tags_seen;
            r_vid_store   <= n_vid_store;
            r_type_hi     <= n_type_hi;
        end
    end

endmodule

>>> hw/rtl/evhp_outbuf.sv
module evhp_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  evhp_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_full,
    output logic              o_valid,
    output evhp_pkg::t_result o_result
);
    import evhp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> hw/rtl/ethernet_vlan_header_parser_top.sv
// Ethernet header parser with 802.1Q / 802.1ad tag skipping.
// Input channel: i_valid / o_stall carry one packet byte per transaction
// (i_data_byte, i_last_byte marks the final byte). Output channel:
// o_valid / i_stall carry one header record per packet.
// A record is produced for the byte that completes the header (EtherType
// not a tag type, or tag limit reached) or for the last byte if the header
// was still open; o_truncated is set, with all other fields zero, when the
// packet ended before 14 bytes. Bytes after a complete header are dropped
// until the last byte, which rearms the parser.
// Throughput: one byte per cycle while o_stall is low. Each record is
// registered in the output register, or in the skid stage if that is busy.
// Reset (synchronous, i_rst_n low) clears the parse state and empties the
// output register and its one-entry skid stage.
// When the receiver stalls, the output register holds its record and one
// more record may land in the skid stage; o_stall then rises and holds
// until the output register drains.
module ethernet_vlan_header_parser_top #(
    parameter int MAX_VLAN_TAGS = evhp_pkg::MaxVlanTags
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_dest_mac,
    output logic [47:0] o_src_mac,
    output logic [15:0] o_ether_type,
    output logic [1:0]  o_tag_count,
    output logic [11:0] o_outer_vid,
    output logic [11:0] o_inner_vid,
    output logic [4:0]  o_header_bytes,
    output logic        o_truncated
);
    import evhp_pkg::*;

    logic    acc;
    logic    push;
    logic    full;
    t_result res_in;
    t_result res_out;

    assign o_stall = full;
    assign acc     = i_valid && !full;

    evhp_parse #(
        .MAX_VLAN_TAGS(MAX_VLAN_TAGS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_push     (push),
        .o_result   (res_in)
    );

    evhp_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_result(res_in),
        .i_stall (i_stall),
        .o_full  (full),
        .o_valid (o_valid),
        .o_result(res_out)
    );

    assign o_dest_mac     = res_out.dest_mac;
    assign o_src_mac      = res_out.src_mac;
    assign o_ether_type   = res_out.ether_type;
    assign o_tag_count    = res_out.tag_count;
    assign o_outer_vid    = res_out.outer_vid;
    assign o_inner_vid    = res_out.inner_vid;
    assign o_header_bytes = res_out.header_bytes;
    assign o_truncated    = res_out.truncated;

endmodule

>>> hw/rtl/evhp_checker.sv
module evhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [47:0] o_dest_mac,
    input logic [47:0] o_src_mac,
    input logic [15:0] o_ether_type,
    input logic [1:0]  o_tag_count,
    input logic [11:0] o_outer_vid,
    input logic [11:0] o_inner_vid,
    input logic [4:0]  o_header_bytes,
    input logic        o_truncated
);
    import evhp_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data_byte) && $stable(i_last_byte))
        else $error("stalled input transaction changed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_mac) && $stable(o_src_mac) &&
            $stable(o_ether_type) && $stable(o_header_bytes) && $stable(o_truncated))
        else $error("stalled record changed");

    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_dest_mac == '0 && o_src_mac == '0 &&
            o_ether_type == '0 && o_tag_count == '0 && o_header_bytes == '0)
        else $error("truncated record carries header data");

    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_truncated |-> o_tag_count <= 2'd2 &&
            o_header_bytes == 5'(EthHdrLen) + {1'b0, o_tag_count, 2'b00})
        else $error("header length does not match tag count");

    a_vid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tag_count != 2'd2 |-> o_inner_vid == '0 &&
            (o_tag_count != 2'd0 || o_outer_vid == '0))
        else $error("VID present without its tag");

endmodule

bind ethernet_vlan_header_parser_top evhp_checker u_evhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_data_byte   (i_data_byte),
    .i_last_byte   (i_last_byte),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_dest_mac    (o_dest_mac),
    .o_src_mac     (o_src_mac),
    .o_ether_type  (o_ether_type),
    .o_tag_count   (o_tag_count),
    .o_outer_vid   (o_outer_vid),
    .o_inner_vid   (o_inner_vid),
    .o_header_bytes(o_header_bytes),
    .o_truncated   (o_truncated)
);
